### hdl/ssp_pkg.sv
// Shared constants and types for the servo status packet parser.
package ssp_pkg;

  // Number of parameter bytes held from each packet.
  localparam int KEPT_PARAMS = 8;

  // Bits needed to address one kept parameter slot.
  localparam int SLOT_W = (KEPT_PARAMS > 1) ? $clog2(KEPT_PARAMS) : 1;

  // Header byte value and the count of bytes not counted as parameters.
  localparam logic [7:0] HDR_BYTE = 8'hff;
  localparam logic [7:0] LEN_BIAS = 8'd2;

  // One result beat as it travels from the parser to the output buffer.
  typedef struct packed {
    logic        checksum_ok;
    logic        telemetry_updated;
    logic [7:0]  error_status;
    logic [15:0] position;
    logic [15:0] speed;
    logic [15:0] load;
    logic [7:0]  voltage;
    logic [7:0]  temperature;
    logic [7:0]  param_count;
  } ssp_result_t;

endpackage

### hdl/servo_status_packet_parser.sv
// Top level of the servo status packet parser.
//
//   Channel  Ports                                   Direction
//   in       in_valid, in_stall, in_kind, in_rx_byte  beats into the block
//   out      out_valid, out_stall, out_* fields      one result per checksum
//
// One beat is taken every cycle unless in_stall is high; the parser state
// updates at the accepting edge, where a checksum result is also registered.
// Reset (rst_n low, synchronous) clears the parser, the parameter slots and
// the output buffer. A stalled result waits in the output register while a
// skid slot takes one more; in_stall rises only while that slot is full.
module servo_status_packet_parser
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_checksum_ok,
  output logic        out_telemetry_updated,
  output logic [7:0]  out_error_status,
  output logic [15:0] out_position,
  output logic [15:0] out_speed,
  output logic [15:0] out_load,
  output logic [7:0]  out_voltage,
  output logic [7:0]  out_temperature,
  output logic [7:0]  out_param_count
);

  logic        beat_take;
  logic        res_valid;
  ssp_result_t res_data;
  logic        buf_full;
  ssp_result_t out_data;

  assign in_stall  = buf_full;
  assign beat_take = in_valid && !buf_full;

  // Parser core.
  ssp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_take (beat_take),
    .kind      (in_kind),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // Output register and skid slot.
  ssp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (beat_take && res_valid),
    .push_data (res_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Unpack the result beat onto its ports.
  assign out_checksum_ok       = out_data.checksum_ok;
  assign out_telemetry_updated = out_data.telemetry_updated;
  assign out_error_status      = out_data.error_status;
  assign out_position          = out_data.position;
  assign out_speed             = out_data.speed;
  assign out_load              = out_data.load;
  assign out_voltage           = out_data.voltage;
  assign out_temperature       = out_data.temperature;
  assign out_param_count       = out_data.param_count;

endmodule

### hdl/ssp_parser.sv
// Byte-wide packet parser: header hunt, running checksum and parameter store.
module ssp_parser
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        beat_take,
  input  logic        kind,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output ssp_result_t res_data
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_ERR  = 3'd4,
    PH_PAR  = 3'd5,
    PH_CHK  = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  expected_r, expected_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [7:0]  last_error_r, last_error_nxt;
  logic        poll_armed_r, poll_armed_nxt;
  logic [7:0]  store_r [KEPT_PARAMS];
  logic        store_we;
  logic        ok;
  logic        pub;

  // Checksum compare and publish decision for a checksum beat.
  assign ok  = (~sum_r) == rx_byte;
  assign pub = ok && poll_armed_r;

  // Next-state decode for one accepted beat.
  always_comb begin
    phase_nxt      = phase_r;
    sum_nxt        = sum_r;
    expected_nxt   = expected_r;
    seen_nxt       = seen_r;
    last_error_nxt = last_error_r;
    poll_armed_nxt = poll_armed_r;
    store_we       = 1'b0;
    res_valid      = 1'b0;
    if (kind) begin
      // A poll request only arms the decode.
      poll_armed_nxt = 1'b1;
    end else begin
      case (phase_r)
        PH_HDR0: begin
          if (rx_byte == HDR_BYTE) phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          phase_nxt = (rx_byte == HDR_BYTE) ? PH_ID : PH_HDR0;
        end
        PH_ID: begin
          sum_nxt   = rx_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          expected_nxt = rx_byte - LEN_BIAS;
          sum_nxt      = sum_r + rx_byte;
          phase_nxt    = PH_ERR;
        end
        PH_ERR: begin
          last_error_nxt = rx_byte;
          sum_nxt        = sum_r + rx_byte;
          seen_nxt       = 8'd0;
          phase_nxt      = (expected_r != 8'd0) ? PH_PAR : PH_CHK;
        end
        PH_PAR: begin
          sum_nxt  = sum_r + rx_byte;
          // Bytes past the kept slots still count in the sum but are dropped.
          store_we = {1'b0, seen_r} < 9'(KEPT_PARAMS);
          if (seen_r == (expected_r - 8'd1)) phase_nxt = PH_CHK;
          seen_nxt = seen_r + 8'd1;
        end
        PH_CHK: begin
          res_valid      = 1'b1;
          phase_nxt      = PH_HDR0;
          poll_armed_nxt = 1'b0;
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase
    end
  end

  // Result fields; telemetry reads as zero unless it is published.
  always_comb begin
    res_data                   = '0;
    res_data.checksum_ok       = ok;
    res_data.telemetry_updated = pub;
    res_data.error_status      = last_error_r;
    res_data.param_count       = expected_r;
    if (pub) begin
      res_data.position    = {store_r[1], store_r[0]};
      res_data.speed       = {store_r[3], store_r[2]};
      res_data.load        = {store_r[5], store_r[4]};
      res_data.voltage     = store_r[6];
      res_data.temperature = store_r[7];
    end
  end

  // Parser state and the parameter slots, updated on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR0;
      sum_r        <= 8'd0;
      expected_r   <= 8'd0;
      seen_r       <= 8'd0;
      last_error_r <= 8'd0;
      poll_armed_r <= 1'b0;
      for (int i = 0; i < KEPT_PARAMS; i++) store_r[i] <= 8'd0;
    end else if (beat_take) begin
      phase_r      <= phase_nxt;
      sum_r        <= sum_nxt;
      expected_r   <= expected_nxt;
      seen_r       <= seen_nxt;
      last_error_r <= last_error_nxt;
      poll_armed_r <= poll_armed_nxt;
      if (store_we) store_r[seen_r[SLOT_W-1:0]] <= rx_byte;
    end
  end

endmodule

### hdl/ssp_out_buf.sv
// Result register with a skid slot so input stall is driven from a flop.
module ssp_out_buf
  import ssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ssp_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output ssp_result_t out_data
);

  logic        main_valid_r;
  ssp_result_t main_data_r;
  logic        skid_valid_r;
  ssp_result_t skid_data_r;
  logic        main_free;

  // The main register can load when empty or when its beat leaves now.
  assign main_free = !main_valid_r || !out_stall;

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (main_free) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload registers; the skid slot is drained before new beats load.
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule
